### rtl/mssst_pkg.sv
// Types, widths and outcome codes for the moving sphere pair test.
// No dependencies; every other file in rtl imports this package.
package mssst_pkg;

    // Field widths of the request and response
    localparam int COORD_BITS  = 24;
    localparam int RADIUS_BITS = 20;
    localparam int MOTION_BITS = 20;
    localparam int TIME_BITS   = 24;
    localparam int TIME_FRAC   = 16;
    localparam int TIME_INT    = TIME_BITS - TIME_FRAC;

    // Internal widths, all sized for the worst case magnitudes
    localparam int SW    = COORD_BITS + 1;        // centre offset, signed
    localparam int SQ_W  = 2 * COORD_BITS + 1;    // one squared offset term
    localparam int SS_W  = 2 * COORD_BITS + 2;    // |s|^2
    localparam int RS_W  = RADIUS_BITS + 1;       // radius sum
    localparam int RR_W  = 2 * RS_W;              // radius sum squared
    localparam int V2_W  = 2 * MOTION_BITS - 1;   // one squared motion term
    localparam int A_W   = 2 * MOTION_BITS;       // |v|^2
    localparam int VS_W  = MOTION_BITS + SW;      // one v.s term, signed
    localparam int B_W   = VS_W + 1;              // v.s, signed
    localparam int NB_W  = B_W - 1;               // -b when b is negative
    localparam int D_W   = 2 * NB_W;              // b^2, a*c, discriminant
    localparam int Q_W   = NB_W;                  // square root of discriminant

    typedef enum logic [2:0] {
        OUT_OVERLAP = 3'd0,
        OUT_STILL   = 3'd1,
        OUT_APART   = 3'd2,
        OUT_MISS    = 3'd3,
        OUT_CONTACT = 3'd4
    } t_outcome;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  first_center_x;
        logic signed [COORD_BITS-1:0]  first_center_y;
        logic signed [COORD_BITS-1:0]  first_center_z;
        logic signed [COORD_BITS-1:0]  second_center_x;
        logic signed [COORD_BITS-1:0]  second_center_y;
        logic signed [COORD_BITS-1:0]  second_center_z;
        logic [RADIUS_BITS-1:0]        first_radius;
        logic [RADIUS_BITS-1:0]        second_radius;
        logic signed [MOTION_BITS-1:0] rel_motion_x;
        logic signed [MOTION_BITS-1:0] rel_motion_y;
        logic signed [MOTION_BITS-1:0] rel_motion_z;
    } t_in_req;

    typedef struct packed {
        logic                 hit;
        t_outcome             outcome;
        logic [TIME_BITS-1:0] contact_time;
    } t_out_rsp;

    // Side data carried alongside the square root pipe
    typedef struct packed {
        t_outcome         code;
        logic [NB_W-1:0]  nb;
        logic [A_W-1:0]   a;
    } t_sq_side;

    // Side data carried alongside the divider pipe
    typedef struct packed {
        t_outcome code;
        logic     sat;
    } t_dv_side;

endpackage

### rtl/moving_sphere_sphere_test.sv
// Moving sphere pair intersection test, pipelined from request to response
// (7 arithmetic stages, a 45-stage square root, 1 stage, a 24-stage divider, output).
// Throughput one request per cycle; the whole pipe holds while the response is not taken.
// Reset (synchronous, active low) clears all stage valid bits; data registers are not reset.
// Depends on mssst_pkg, mssst_sqrt and mssst_div.
module moving_sphere_sphere_test
    import mssst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_rsp o_out_rsp
);

    localparam int NL = NB_W / 2;
    localparam int NH = NB_W - NL;
    localparam int CL = SS_W / 2;
    localparam int CH = SS_W - CL;
    localparam int AL = A_W / 2;
    localparam int AH = A_W - AL;
    localparam int CMP_W = (NB_W > A_W + TIME_INT) ? NB_W : A_W + TIME_INT;

    logic w_adv;

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------- stage 1: offsets and radius sum ----------------
    logic signed [COORD_BITS-1:0]  w_p1 [3];
    logic signed [COORD_BITS-1:0]  w_p2 [3];
    logic signed [MOTION_BITS-1:0] w_mv [3];
    logic signed [SW-1:0]          n1_s [3];

    logic                          r1_vld;
    logic signed [SW-1:0]          r1_s [3];
    logic signed [MOTION_BITS-1:0] r1_m [3];
    logic [RS_W-1:0]               r1_rs;

    assign w_p1[0] = i_in_req.first_center_x;
    assign w_p1[1] = i_in_req.first_center_y;
    assign w_p1[2] = i_in_req.first_center_z;
    assign w_p2[0] = i_in_req.second_center_x;
    assign w_p2[1] = i_in_req.second_center_y;
    assign w_p2[2] = i_in_req.second_center_z;
    assign w_mv[0] = i_in_req.rel_motion_x;
    assign w_mv[1] = i_in_req.rel_motion_y;
    assign w_mv[2] = i_in_req.rel_motion_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_s[i] = SW'(w_p2[i]) - SW'(w_p1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_s[i] <= n1_s[i];
                r1_m[i] <= w_mv[i];
            end
            r1_rs <= RS_W'(i_in_req.first_radius) + RS_W'(i_in_req.second_radius);
        end
    end

    // ---------------- stage 2: per-axis products ----------------
    logic signed [2*SW-1:0]          n2_sq [3];
    logic signed [2*MOTION_BITS-1:0] n2_vv [3];
    logic signed [VS_W-1:0]          n2_vs [3];

    logic                   r2_vld;
    logic [SQ_W-1:0]        r2_ss [3];
    logic [V2_W-1:0]        r2_vv [3];
    logic signed [VS_W-1:0] r2_vs [3];
    logic [RR_W-1:0]        r2_rr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_sq[i] = r1_s[i] * r1_s[i];
            n2_vv[i] = r1_m[i] * r1_m[i];
            n2_vs[i] = VS_W'(r1_m[i]) * VS_W'(r1_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_ss[i] <= n2_sq[i][SQ_W-1:0];
                r2_vv[i] <= n2_vv[i][V2_W-1:0];
                r2_vs[i] <= n2_vs[i];
            end
            r2_rr <= RR_W'(r1_rs) * RR_W'(r1_rs);
        end
    end

    // ---------------- stage 3: dot product sums ----------------
    logic                  r3_vld;
    logic [SS_W-1:0]       r3_ss;
    logic [A_W-1:0]        r3_a;
    logic signed [B_W-1:0] r3_b;
    logic [RR_W-1:0]       r3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ss <= SS_W'(r2_ss[0]) + SS_W'(r2_ss[1]) + SS_W'(r2_ss[2]);
            r3_a  <= A_W'(r2_vv[0]) + A_W'(r2_vv[1]) + A_W'(r2_vv[2]);
            r3_b  <= B_W'(r2_vs[0]) + B_W'(r2_vs[1]) + B_W'(r2_vs[2]);
            r3_rr <= r2_rr;
        end
    end

    // ---------------- stage 4: c and the early outcomes ----------------
    logic [SS_W:0]  n4_c;
    logic [B_W-1:0] n4_negb;
    t_outcome       n4_code;

    logic            r4_vld;
    logic [SS_W-1:0] r4_c;
    logic [A_W-1:0]  r4_a;
    logic [NB_W-1:0] r4_nb;
    t_outcome        r4_code;

    always_comb begin
        n4_c    = {1'b0, r3_ss} - (SS_W + 1)'(r3_rr);
        n4_negb = -r3_b;
        if (n4_c[SS_W]) begin
            n4_code = OUT_OVERLAP;
        end else if (r3_a == '0) begin
            n4_code = OUT_STILL;
        end else if (!r3_b[B_W-1]) begin
            n4_code = OUT_APART;
        end else begin
            n4_code = OUT_CONTACT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_c    <= n4_c[SS_W-1:0];
            r4_a    <= r3_a;
            r4_nb   <= n4_negb[NB_W-1:0];
            r4_code <= n4_code;
        end
    end

    // ---------------- stage 5: partial products of b^2 and a*c ----------------
    logic            r5_vld;
    logic [2*NL-1:0] r5_bll;
    logic [NL+NH-1:0] r5_blh;
    logic [2*NH-1:0] r5_bhh;
    logic [CL+AL-1:0] r5_cll;
    logic [CL+AH-1:0] r5_clh;
    logic [CH+AL-1:0] r5_chl;
    logic [CH+AH-1:0] r5_chh;
    logic [A_W-1:0]  r5_a;
    logic [NB_W-1:0] r5_nb;
    t_outcome        r5_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_bll  <= (2*NL)'(r4_nb[NL-1:0]) * (2*NL)'(r4_nb[NL-1:0]);
            r5_blh  <= (NL+NH)'(r4_nb[NL-1:0]) * (NL+NH)'(r4_nb[NB_W-1:NL]);
            r5_bhh  <= (2*NH)'(r4_nb[NB_W-1:NL]) * (2*NH)'(r4_nb[NB_W-1:NL]);
            r5_cll  <= (CL+AL)'(r4_c[CL-1:0]) * (CL+AL)'(r4_a[AL-1:0]);
            r5_clh  <= (CL+AH)'(r4_c[CL-1:0]) * (CL+AH)'(r4_a[A_W-1:AL]);
            r5_chl  <= (CH+AL)'(r4_c[SS_W-1:CL]) * (CH+AL)'(r4_a[AL-1:0]);
            r5_chh  <= (CH+AH)'(r4_c[SS_W-1:CL]) * (CH+AH)'(r4_a[A_W-1:AL]);
            r5_a    <= r4_a;
            r5_nb   <= r4_nb;
            r5_code <= r4_code;
        end
    end

    // ---------------- stage 6: assemble b^2 and a*c ----------------
    logic            r6_vld;
    logic [D_W-1:0]  r6_bb;
    logic [D_W-1:0]  r6_ac;
    logic [A_W-1:0]  r6_a;
    logic [NB_W-1:0] r6_nb;
    t_outcome        r6_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_adv) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_bb   <= D_W'(r5_bll) + (D_W'(r5_blh) << (NL + 1))
                     + (D_W'(r5_bhh) << (2 * NL));
            r6_ac   <= D_W'(r5_cll) + (D_W'(r5_clh) << AL)
                     + (D_W'(r5_chl) << CL) + (D_W'(r5_chh) << (CL + AL));
            r6_a    <= r5_a;
            r6_nb   <= r5_nb;
            r6_code <= r5_code;
        end
    end

    // ---------------- stage 7: discriminant and miss test ----------------
    logic [D_W:0] n7_d;
    t_sq_side     n7_side;

    logic           r7_vld;
    logic [D_W-1:0] r7_d;
    t_sq_side       r7_side;

    always_comb begin
        n7_d         = {1'b0, r6_bb} - {1'b0, r6_ac};
        n7_side.nb   = r6_nb;
        n7_side.a    = r6_a;
        n7_side.code = (r6_code == OUT_CONTACT && n7_d[D_W]) ? OUT_MISS : r6_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_d    <= n7_d[D_W-1:0];
            r7_side <= n7_side;
        end
    end

    // ---------------- square root of the discriminant ----------------
    logic           w_sq_vld;
    logic [Q_W-1:0] w_sq_root;
    t_sq_side       w_sq_side;

    mssst_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r7_vld),
        .i_rad   (r7_d),
        .i_side  (r7_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    // ---------------- stage 8: numerator and saturation test ----------------
    logic [NB_W-1:0] n8_n;
    t_dv_side        n8_side;

    logic                 r8_vld;
    logic [A_W-1:0]       r8_rem;
    logic [TIME_BITS-1:0] r8_low;
    logic [A_W-1:0]       r8_a;
    t_dv_side             r8_side;

    always_comb begin
        n8_n         = w_sq_side.nb - w_sq_root;
        n8_side.code = w_sq_side.code;
        n8_side.sat  = CMP_W'(n8_n) >= CMP_W'({w_sq_side.a, TIME_INT'(0)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_adv) begin
            r8_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_rem  <= A_W'(n8_n >> TIME_INT);
            r8_low  <= {n8_n[TIME_INT-1:0], TIME_FRAC'(0)};
            r8_a    <= w_sq_side.a;
            r8_side <= n8_side;
        end
    end

    // ---------------- contact time division ----------------
    logic                 w_dv_vld;
    logic [TIME_BITS-1:0] w_dv_quo;
    t_dv_side             w_dv_side;

    mssst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r8_vld),
        .i_rem   (r8_rem),
        .i_low   (r8_low),
        .i_den   (r8_a),
        .i_side  (r8_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // ---------------- output register ----------------
    t_out_rsp n_out;
    logic     r_out_vld;
    t_out_rsp r_out;

    always_comb begin
        n_out.outcome = w_dv_side.code;
        n_out.hit     = (w_dv_side.code == OUT_OVERLAP) || (w_dv_side.code == OUT_CONTACT);
        if (w_dv_side.code != OUT_CONTACT) begin
            n_out.contact_time = '0;
        end else if (w_dv_side.sat) begin
            n_out.contact_time = '1;
        end else begin
            n_out.contact_time = w_dv_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    // ---------------- checks ----------------
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.hit ==
            (o_out_rsp.outcome == OUT_OVERLAP || o_out_rsp.outcome == OUT_CONTACT))
        else $error("hit flag disagrees with outcome");

    a_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.outcome != OUT_CONTACT |-> o_out_rsp.contact_time == '0)
        else $error("contact time set without contact");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r8_vld && r8_side.code == OUT_CONTACT && !r8_side.sat |-> r8_rem < r8_a)
        else $error("divider entered with remainder not below divisor");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r8_vld) && $stable(r1_vld) && $stable(r_out_vld))
        else $error("pipeline moved while held");

endmodule

### rtl/mssst_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on mssst_pkg for widths and the side data type.
module mssst_sqrt
    import mssst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [D_W-1:0]   i_rad,
    input  t_sq_side         i_side,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_root,
    output t_sq_side         o_side
);

    localparam int REM_W = Q_W + 3;

    logic             r_vld  [Q_W];
    logic [REM_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_root [Q_W];
    logic [D_W-1:0]   r_rad  [Q_W];
    t_sq_side         r_side [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic             w_vld;
            logic [REM_W-1:0] w_rem;
            logic [Q_W-1:0]   w_root;
            logic [D_W-1:0]   w_rad;
            t_sq_side         w_side;
            logic [REM_W-1:0] n_sh;
            logic [REM_W:0]   n_trial;
            logic [REM_W-1:0] n_rem;
            logic [Q_W-1:0]   n_root;

            if (k == 0) begin : g_first
                assign w_vld  = i_vld;
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_rad  = i_rad;
                assign w_side = i_side;
            end else begin : g_next
                assign w_vld  = r_vld[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_root = r_root[k-1];
                assign w_rad  = r_rad[k-1];
                assign w_side = r_side[k-1];
            end

            // bring down two radicand bits and try the next root bit
            always_comb begin
                n_sh    = {w_rem[REM_W-3:0], w_rad[D_W-1 -: 2]};
                n_trial = {1'b0, n_sh} - (REM_W + 1)'({w_root, 2'b01});
                if (!n_trial[REM_W]) begin
                    n_rem  = n_trial[REM_W-1:0];
                    n_root = {w_root[Q_W-2:0], 1'b1};
                end else begin
                    n_rem  = n_sh;
                    n_root = {w_root[Q_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_adv) begin
                    r_vld[k] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_rad[k]  <= w_rad << 2;
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[Q_W-1];
    assign o_root = r_root[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

### rtl/mssst_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on mssst_pkg for widths and the side data type.
module mssst_div
    import mssst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  logic [A_W-1:0]       i_rem,
    input  logic [TIME_BITS-1:0] i_low,
    input  logic [A_W-1:0]       i_den,
    input  t_dv_side             i_side,
    output logic                 o_vld,
    output logic [TIME_BITS-1:0] o_quo,
    output t_dv_side             o_side
);

    logic                 r_vld  [TIME_BITS];
    logic [A_W-1:0]       r_rem  [TIME_BITS];
    logic [TIME_BITS-1:0] r_low  [TIME_BITS];
    logic [TIME_BITS-1:0] r_quo  [TIME_BITS];
    logic [A_W-1:0]       r_den  [TIME_BITS];
    t_dv_side             r_side [TIME_BITS];

    genvar k;
    generate
        for (k = 0; k < TIME_BITS; k++) begin : g_stage
            logic                 w_vld;
            logic [A_W-1:0]       w_rem;
            logic [TIME_BITS-1:0] w_low;
            logic [TIME_BITS-1:0] w_quo;
            logic [A_W-1:0]       w_den;
            t_dv_side             w_side;
            logic [A_W:0]         n_sh;
            logic [A_W+1:0]       n_diff;
            logic                 n_ge;
            logic [A_W-1:0]       n_rem;

            if (k == 0) begin : g_first
                assign w_vld  = i_vld;
                assign w_rem  = i_rem;
                assign w_low  = i_low;
                assign w_quo  = '0;
                assign w_den  = i_den;
                assign w_side = i_side;
            end else begin : g_next
                assign w_vld  = r_vld[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_low  = r_low[k-1];
                assign w_quo  = r_quo[k-1];
                assign w_den  = r_den[k-1];
                assign w_side = r_side[k-1];
            end

            // shift in the next dividend bit, subtract the divisor if it fits
            always_comb begin
                n_sh   = {w_rem, w_low[TIME_BITS-1]};
                n_diff = {1'b0, n_sh} - (A_W + 2)'(w_den);
                n_ge   = !n_diff[A_W+1];
                n_rem  = n_ge ? n_diff[A_W-1:0] : n_sh[A_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_adv) begin
                    r_vld[k] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k]  <= n_rem;
                    r_low[k]  <= w_low << 1;
                    r_quo[k]  <= {w_quo[TIME_BITS-2:0], n_ge};
                    r_den[k]  <= w_den;
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[TIME_BITS-1];
    assign o_quo  = r_quo[TIME_BITS-1];
    assign o_side = r_side[TIME_BITS-1];

endmodule

### sim/tb.sv
// Self-checking bench for moving_sphere_sphere_test: directed and random sphere pairs.
// Depends on mssst_pkg and the RTL of the block; a scoreboard class holds expected responses.
`timescale 1ns / 100ps

module tb;
    import mssst_pkg::*;

    // Scoreboard: predict the outcome of each request, compare responses in order
    class sphere_scoreboard;
        t_out_rsp pending[$];
        int       n_mismatch;
        int       n_checked;
        int       n_outcome[5];

        // Integer square root by bit-wise trial
        function logic [127:0] isqrt(logic [127:0] d);
            logic [127:0] res;
            logic [127:0] cand;
            res = '0;
            for (int k = 63; k >= 0; k--) begin
                cand = res | (128'd1 << k);
                if (cand * cand <= d) res = cand;
            end
            return res;
        endfunction

        function t_out_rsp predict(t_in_req r);
            t_out_rsp         p;
            logic signed [127:0] s [3];
            logic signed [127:0] v [3];
            logic signed [127:0] ss, rr, a, b, c, disc, q, n, t;
            logic [127:0]     rsum;
            ss = 0; a = 0; b = 0;
            s[0] = 128'(r.second_center_x) - 128'(r.first_center_x);
            s[1] = 128'(r.second_center_y) - 128'(r.first_center_y);
            s[2] = 128'(r.second_center_z) - 128'(r.first_center_z);
            v[0] = 128'(r.rel_motion_x);
            v[1] = 128'(r.rel_motion_y);
            v[2] = 128'(r.rel_motion_z);
            for (int i = 0; i < 3; i++) begin
                ss += s[i] * s[i];
                a  += v[i] * v[i];
                b  += v[i] * s[i];
            end
            rsum = 128'(r.first_radius) + 128'(r.second_radius);
            rr = rsum * rsum;
            c = ss - rr;
            p.contact_time = '0;
            if (c < 0) p.outcome = OUT_OVERLAP;
            else if (a == 0) p.outcome = OUT_STILL;
            else if (b >= 0) p.outcome = OUT_APART;
            else begin
                disc = b * b - a * c;
                if (disc < 0) p.outcome = OUT_MISS;
                else begin
                    p.outcome = OUT_CONTACT;
                    q = isqrt(disc);
                    n = -b - q;
                    t = (n <<< TIME_FRAC) / a;
                    p.contact_time = (t >= (128'sd1 <<< TIME_BITS)) ? '1 : t[TIME_BITS-1:0];
                end
            end
            p.hit = (p.outcome == OUT_OVERLAP || p.outcome == OUT_CONTACT);
            return p;
        endfunction

        function void note_request(t_in_req r);
            pending.insert(pending.size(), predict(r));
        endfunction

        function void check_response(t_out_rsp got);
            t_out_rsp want;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected response %p", got);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            n_outcome[want.outcome]++;
            if (got.hit !== want.hit || got.outcome !== want.outcome ||
                got.contact_time !== want.contact_time) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display({"mismatch: want hit=%0d outcome=%0d time=%0h, ",
                              "got hit=%0d outcome=%0d time=%0h"},
                             want.hit, want.outcome, want.contact_time,
                             got.hit, got.outcome, got.contact_time);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_rsp o_out_rsp;

    sphere_scoreboard board;
    bit       idle_rx;

    moving_sphere_sphere_test uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request and hold it until accepted; returns at a falling edge
    task automatic send_request(t_in_req r);
        int g;
        g = idle_rx ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    function automatic t_in_req random_pair(int mode);
        t_in_req r;
        int      k;
        r = $bits(t_in_req)'({$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
        case (mode)
            0: ; // full-range noise
            1: begin
                // close pairs moving toward each other, small numbers
                r.first_center_x = $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
                r.first_center_y = $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
                r.first_center_z = $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
                r.second_center_x = r.first_center_x
                                  + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
                r.second_center_y = r.first_center_y
                                  + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
                r.second_center_z = r.first_center_z
                                  + $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
                r.first_radius  = 20'($urandom_range(0, 600));
                r.second_radius = 20'($urandom_range(0, 600));
                k = $urandom_range(0, 3);
                r.rel_motion_x = 20'(-((r.second_center_x - r.first_center_x) >>> k)
                                 + $signed(24'($urandom_range(0, 200))) - 24'sd100);
                r.rel_motion_y = 20'(-((r.second_center_y - r.first_center_y) >>> k)
                                 + $signed(24'($urandom_range(0, 200))) - 24'sd100);
                r.rel_motion_z = 20'(-((r.second_center_z - r.first_center_z) >>> k)
                                 + $signed(24'($urandom_range(0, 200))) - 24'sd100);
            end
            default: begin
                // tiny motion toward distant spheres: saturating times
                r.first_center_x = '0; r.first_center_y = '0; r.first_center_z = '0;
                r.second_center_x = 24'($urandom_range(0, 8388607));
                r.second_center_y = 24'($urandom_range(0, 1000));
                r.second_center_z = '0;
                r.first_radius  = 20'($urandom);
                r.second_radius = 20'($urandom);
                r.rel_motion_x = -$signed(20'($urandom_range(1, 300)));
                r.rel_motion_y = '0;
                r.rel_motion_z = 20'($urandom_range(0, 1));
            end
        endcase
        return r;
    endfunction

    task automatic run_directed();
        t_in_req r;
        // all-zero: touching exactly, then still
        r = '0; send_request(r);
        // overlapping
        r = '0; r.first_radius = 20'd1; send_request(r);
        // extremes of centres and radii
        r = '0;
        r.first_center_x = 24'sh800000; r.first_center_y = 24'sh800000;
        r.first_center_z = 24'sh800000;
        r.second_center_x = 24'sh7fffff; r.second_center_y = 24'sh7fffff;
        r.second_center_z = 24'sh7fffff;
        r.rel_motion_x = 20'sh80000; r.rel_motion_y = 20'sh80000;
        r.rel_motion_z = 20'sh80000;
        send_request(r);
        r.first_radius = '1; r.second_radius = '1; send_request(r);
        r.rel_motion_x = 20'sh7ffff; r.rel_motion_y = 20'sh7ffff;
        r.rel_motion_z = 20'sh7ffff; r.first_radius = '0; r.second_radius = '0;
        send_request(r);
        // touching exactly, stationary
        r = '0; r.second_center_x = 24'sd512; r.first_radius = 20'd256;
        r.second_radius = 20'd256; send_request(r);
        // touching exactly, separating
        r.rel_motion_x = 20'sd1; send_request(r);
        // touching exactly, approaching: contact at zero
        r.rel_motion_x = -20'sd1; send_request(r);
        // head-on contact at half a step
        r = '0; r.second_center_x = 24'sd1024; r.first_radius = 20'd256;
        r.second_radius = 20'd256; r.rel_motion_x = -20'sd1024; send_request(r);
        // passing by sideways: miss
        r.second_center_y = 24'sd5000; r.second_center_x = 24'sd5000; send_request(r);
        // grazing contact with zero discriminant
        r = '0; r.second_center_x = 24'sd1000; r.second_center_y = 24'sd512;
        r.first_radius = 20'd512; r.rel_motion_x = -20'sd10; send_request(r);
        // very slow approach: saturated time
        r = '0; r.second_center_x = 24'sh7fffff; r.rel_motion_x = -20'sd1; send_request(r);
        // negative coordinates, opposite direction
        r = '0; r.second_center_z = -24'sd3000; r.second_radius = 20'd100;
        r.rel_motion_z = 20'sd2000; send_request(r);
        // every bit of every field both ways
        r = '1; send_request(r);
        r = $bits(t_in_req)'({11{24'h555555}}); send_request(r);
        r = $bits(t_in_req)'({11{24'haaaaaa}}); send_request(r);
    endtask

    // Response side: random stalls, with stall-free stretches
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            i_out_ready <= idle_rx ? 1'b1 : ($urandom_range(0, 99) < 35 ? 1'b0 : 1'b1);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_response(o_out_rsp);
        end
    end

    initial begin
        int m;
        board      = new();
        idle_rx    = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        for (int i = 0; i < 700; i++) begin
            if (i % 150 == 100) idle_rx = 1'b1;
            if (i % 150 == 140) idle_rx = 1'b0;
            m = $urandom_range(0, 9);
            send_request(random_pair(m < 2 ? 0 : (m < 9 ? 1 : 2)));
        end
        i_in_valid <= 1'b0;
        idle_rx = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d responses checked: overlap %0d, still %0d, apart %0d, miss %0d, contact %0d",
                 board.n_checked, board.n_outcome[0], board.n_outcome[1],
                 board.n_outcome[2], board.n_outcome[3], board.n_outcome[4]);
        $display("%0d mismatches", board.n_mismatch);
        if (board.n_mismatch == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #20000000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/mssst_pkg.sv
rtl/mssst_sqrt.sv
rtl/mssst_div.sv
rtl/moving_sphere_sphere_test.sv
sim/tb.sv
